/* src/ssr_pkg.sv */
// Shared types and constants for the stream search and replace block.
package ssr_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int REPLACE_MAX = 16;

	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 64;
	localparam int NUM_BYTES = 2 * WORD_W / BYTE_W;
	localparam int LEN_W     = 5;
	localparam int CTR_W     = 16;
	localparam int MAX_W     = 17;
	localparam int CFG_IDX_W = 3;

	localparam int PAT_LIM   = (PATTERN_MAX < NUM_BYTES) ? PATTERN_MAX : NUM_BYTES;
	localparam int REP_LIM   = (REPLACE_MAX < NUM_BYTES) ? REPLACE_MAX : NUM_BYTES;
	localparam int WIN_IDX_W = (PAT_LIM > 1) ? $clog2(PAT_LIM) : 1;
	localparam int REP_IDX_W = (REP_LIM > 1) ? $clog2(REP_LIM) : 1;

	localparam logic [MAX_W-1:0] UNLIMITED_MARK = MAX_W'(65536);
	localparam logic [CTR_W-1:0] COUNTER_TOP    = {CTR_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO   = 3'd0,
		REG_PAT_HI   = 3'd1,
		REG_PAT_LEN  = 3'd2,
		REG_REPL_LO  = 3'd3,
		REG_REPL_HI  = 3'd4,
		REG_REPL_LEN = 3'd5,
		REG_MAX_REPL = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_OLDEST,
		EMIT_REPL,
		EMIT_MARK
	} emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_TRIM,
		ST_ONE,
		ST_REPL,
		ST_TAIL
	} state_t;

	typedef struct packed {
		logic  append;
		logic  decide_hit;
		emit_t emit;
		logic  out_last;
		logic  ctr_clear;
	} ssr_cmd_t;

	typedef struct packed {
		logic count_gt_plen;
		logic match_point;
		logic hit;
		logic rlen_zero;
		logic repl_final;
		logic trim_final;
		logic count_zero;
		logic count_one;
		logic slot_free;
	} ssr_stat_t;

endpackage

/* src/ssr_ctrl.sv */
// Controller state machine that sequences the work of one text item.
module ssr_ctrl import ssr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      end_of_text,
	input  ssr_stat_t stat,
	output ssr_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   last_q;
	logic   emitted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			last_q    <= 1'b0;
			emitted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.append) begin
				last_q    <= end_of_text;
				emitted_q <= 1'b0;
			end else if (cmd.emit != EMIT_NONE) begin
				emitted_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.emit       = EMIT_NONE;
		in_stall       = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.append = 1'b1;
					state_d    = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (stat.count_gt_plen) begin
					state_d = ST_TRIM;
				end else if (stat.match_point) begin
					if (stat.hit) begin
						cmd.decide_hit = 1'b1;
						state_d = stat.rlen_zero ? ST_TAIL : ST_REPL;
					end else begin
						state_d = ST_ONE;
					end
				end else begin
					state_d = ST_TAIL;
				end
			end
			ST_TRIM: begin
				if (stat.slot_free) begin
					cmd.emit     = EMIT_OLDEST;
					cmd.out_last = last_q && stat.count_one;
					if (stat.trim_final) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_ONE: begin
				if (stat.slot_free) begin
					cmd.emit     = EMIT_OLDEST;
					cmd.out_last = last_q && stat.count_one;
					state_d      = ST_TAIL;
				end
			end
			ST_REPL: begin
				if (stat.slot_free) begin
					cmd.emit     = EMIT_REPL;
					cmd.out_last = last_q && stat.repl_final;
					if (stat.repl_final) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_TAIL: begin
				priority if (last_q && !stat.count_zero) begin
					if (stat.slot_free) begin
						cmd.emit     = EMIT_OLDEST;
						cmd.out_last = stat.count_one;
					end
				end else if (last_q && !emitted_q) begin
					if (stat.slot_free) begin
						cmd.emit      = EMIT_MARK;
						cmd.out_last  = 1'b1;
						cmd.ctr_clear = 1'b1;
						state_d       = ST_IDLE;
					end
				end else begin
					cmd.ctr_clear = last_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/ssr_datapath.sv */
// Datapath: configuration registers, byte window, match compare and result register.
module ssr_datapath import ssr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic                 byte_present,
	input  ssr_cmd_t             cmd,
	output ssr_stat_t            stat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 out_byte_present,
	output logic                 out_last,
	output logic [CTR_W-1:0]     replacements_made
);

	logic [NUM_BYTES-1:0][BYTE_W-1:0] pat_q;
	logic [NUM_BYTES-1:0][BYTE_W-1:0] repl_q;
	logic [LEN_W-1:0]                 pat_len_q;
	logic [LEN_W-1:0]                 repl_len_q;
	logic [MAX_W-1:0]                 max_q;

	logic [BYTE_W-1:0]    win_q [PAT_LIM];
	logic [LEN_W-1:0]     cnt_q;
	logic [CTR_W-1:0]     ctr_q;
	logic [REP_IDX_W-1:0] ridx_q;

	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 out_present_q;
	logic                 out_last_q;
	logic [CTR_W-1:0]     out_ctr_q;

	logic [LEN_W-1:0]  plen;
	logic [LEN_W-1:0]  rlen;
	logic              match;
	logic              allowed;
	logic              take_byte;
	logic [BYTE_W-1:0] repl_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q      <= '0;
			repl_q     <= '0;
			pat_len_q  <= '0;
			repl_len_q <= '0;
			max_q      <= UNLIMITED_MARK;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PAT_LO:   pat_q[NUM_BYTES/2-1:0]          <= cfg_data;
				REG_PAT_HI:   pat_q[NUM_BYTES-1:NUM_BYTES/2]  <= cfg_data;
				REG_PAT_LEN:  pat_len_q                       <= cfg_data[LEN_W-1:0];
				REG_REPL_LO:  repl_q[NUM_BYTES/2-1:0]         <= cfg_data;
				REG_REPL_HI:  repl_q[NUM_BYTES-1:NUM_BYTES/2] <= cfg_data;
				REG_REPL_LEN: repl_len_q                      <= cfg_data[LEN_W-1:0];
				REG_MAX_REPL: max_q                           <= cfg_data[MAX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign plen = (pat_len_q > LEN_W'(PAT_LIM)) ? LEN_W'(PAT_LIM) : pat_len_q;
	assign rlen = (repl_len_q > LEN_W'(REP_LIM)) ? LEN_W'(REP_LIM) : repl_len_q;

	// Every window byte below the pattern length is compared with its pattern byte in parallel.
	always_comb begin
		match = 1'b1;
		for (int i = 0; i < PAT_LIM; i++) begin
			if ((LEN_W'(i) < plen) && (win_q[i] != pat_q[i])) begin
				match = 1'b0;
			end
		end
	end

	assign allowed   = max_q[MAX_W-1] || ({1'b0, ctr_q} < max_q);
	assign take_byte = cmd.append && byte_present && (cnt_q < LEN_W'(PAT_LIM));
	assign repl_byte = repl_q[ridx_q];

	always_ff @(posedge clk) begin
		if (take_byte) begin
			win_q[cnt_q[WIN_IDX_W-1:0]] <= text_byte;
		end else if (cmd.emit == EMIT_OLDEST) begin
			for (int k = 0; k < PAT_LIM - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ctr_q  <= '0;
			ridx_q <= '0;
		end else begin
			if (take_byte) begin
				cnt_q <= cnt_q + LEN_W'(1);
			end else if (cmd.decide_hit) begin
				cnt_q <= '0;
			end else if (cmd.emit == EMIT_OLDEST) begin
				cnt_q <= cnt_q - LEN_W'(1);
			end

			if (cmd.decide_hit) begin
				ridx_q <= '0;
			end else if (cmd.emit == EMIT_REPL) begin
				ridx_q <= ridx_q + REP_IDX_W'(1);
			end

			if (cmd.ctr_clear) begin
				ctr_q <= '0;
			end else if (cmd.decide_hit && (ctr_q != COUNTER_TOP)) begin
				ctr_q <= ctr_q + CTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EMIT_NONE) begin
			unique case (cmd.emit)
				EMIT_OLDEST: out_byte_q <= win_q[0];
				EMIT_REPL:   out_byte_q <= repl_byte;
				default:     out_byte_q <= '0;
			endcase
			out_present_q <= (cmd.emit != EMIT_MARK);
			out_last_q    <= cmd.out_last;
			out_ctr_q     <= ctr_q;
		end
	end

	always_comb begin
		stat               = '0;
		stat.count_gt_plen = (cnt_q > plen);
		stat.match_point   = (plen != '0) && (cnt_q == plen);
		stat.hit           = match && allowed;
		stat.rlen_zero     = (rlen == '0);
		stat.repl_final    = ((LEN_W'(ridx_q) + LEN_W'(1)) == rlen);
		stat.trim_final    = (cnt_q == LEN_W'(1)) || (cnt_q <= plen);
		stat.count_zero    = (cnt_q == '0);
		stat.count_one     = (cnt_q == LEN_W'(1));
		stat.slot_free     = !out_valid_q || !out_stall;
	end

	assign out_valid         = out_valid_q;
	assign out_byte          = out_byte_q;
	assign out_byte_present  = out_present_q;
	assign out_last          = out_last_q;
	assign replacements_made = out_ctr_q;

endmodule

/* src/stream_search_and_replace.sv */
// Top level of the stream search and replace block: controller plus datapath.
// An item is accepted and compared, then its results go out one per cycle while the output
// register is free, and then it closes. A bare end marker goes out in the closing cycle itself.
// The first result is visible from the output register after the compare state, and the
// next item waits for the close. A stalled output holds the sequencer.
// Reset is asynchronous: configuration returns to its defaults and the window is empty.
module stream_search_and_replace import ssr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	// Input item channel.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic                 byte_present,
	input  logic                 end_of_text,
	// Result item channel.
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 out_byte_present,
	output logic                 out_last,
	output logic [CTR_W-1:0]     replacements_made
);

	// The controller decides what each cycle does; the datapath reports the
	// window count, the pattern compare and whether the output register is free.
	ssr_cmd_t  cmd;
	ssr_stat_t stat;

	// The controller takes one item at a time. It stalls the input from the
	// cycle after acceptance until every result of that item is in the output
	// register, and drives one result per cycle whenever that register is free.
	ssr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.end_of_text (end_of_text),
		.stat        (stat),
		.cmd         (cmd)
	);

	// The datapath holds the pattern, the replacement, the window of bytes not
	// yet sent on, the replacement counter and the output register. A finished
	// result can wait in the output register while the next item is accepted.
	ssr_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.text_byte         (text_byte),
		.byte_present      (byte_present),
		.cmd               (cmd),
		.stat              (stat),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_byte          (out_byte),
		.out_byte_present  (out_byte_present),
		.out_last          (out_last),
		.replacements_made (replacements_made)
	);

endmodule

/* src/ssr_checker.sv */
// Port-level checks for the stream search and replace block and their binding.
module ssr_checker import ssr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [BYTE_W-1:0]    out_byte,
	input logic                 out_byte_present,
	input logic                 out_last,
	input logic [CTR_W-1:0]     replacements_made
);

	// A stalled result stays valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) &&
			$stable(out_byte_present) && $stable(out_last) && $stable(replacements_made))
		else $error("stalled result item changed");

	// The block works on one item at a time, so it is busy right after taking one.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input item accepted while the previous one was in progress");

	// A bare end marker is only ever the closing result of a text and carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_byte_present |-> out_last && (out_byte == '0))
		else $error("bare end marker without last flag or with a nonzero byte");

	// No result appears while the block is idle waiting for input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !out_valid |=> !out_valid || $past(in_valid))
		else $error("result item produced without an accepted input item");

endmodule

bind stream_search_and_replace ssr_checker u_ssr_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for the stream search and replace block.
`timescale 1ns / 1ps

module testbench;
	import ssr_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 5;
	// The block stalls its input while it works on an item, so once the last result
	// has left, at most one item that causes no result can still be in flight. That
	// item only passes through the compare and close states.
	localparam int SETTLE_CYCLES = 8;
	// The slowest correct run is the random texts under the heaviest stall and gap
	// patterns, plus the directed texts. The limit is several times that.
	localparam int CYCLE_LIMIT     = 400_000;
	localparam int RANDOM_ITEMS    = 350;
	localparam int COUNT_RUN       = 8;
	localparam int ALPHABET_SIZE   = 4;
	localparam int REPORT_LIMIT    = 10;

	// One result item as the block presents it.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              present;
		logic              last;
		logic [CTR_W-1:0]  made;
	} text_out_t;

	// Receiver stall patterns, each held for a random stretch of cycles.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// Scoreboard: keeps its own copy of the registers, the byte window and the
	// replacement counter, works out the result items of every accepted item and
	// checks the block's result items against them in order.
	class text_scoreboard;
		logic [WORD_W-1:0] pat_lo, pat_hi, rep_lo, rep_hi;
		logic [LEN_W-1:0]  pat_len, rep_len;
		logic [MAX_W-1:0]  max_repl;
		logic [BYTE_W-1:0] window [PATTERN_MAX];
		int unsigned       win_count;
		logic [CTR_W-1:0]  repl_count;
		logic [BYTE_W-1:0] step_bytes [$];
		logic              step_real [$];
		text_out_t         expected_text [$];
		int                failures;
		int                reported;
		int                results_seen;

		function new();
			pat_lo       = '0;
			pat_hi       = '0;
			pat_len      = '0;
			rep_lo       = '0;
			rep_hi       = '0;
			rep_len      = '0;
			max_repl     = UNLIMITED_MARK;
			win_count    = 0;
			repl_count   = '0;
			failures     = 0;
			reported     = 0;
			results_seen = 0;
		endfunction

		function void note_write(reg_idx_t idx, logic [WORD_W-1:0] value);
			case (idx)
				REG_PAT_LO:   pat_lo   = value;
				REG_PAT_HI:   pat_hi   = value;
				REG_PAT_LEN:  pat_len  = value[LEN_W-1:0];
				REG_REPL_LO:  rep_lo   = value;
				REG_REPL_HI:  rep_hi   = value;
				REG_REPL_LEN: rep_len  = value[LEN_W-1:0];
				REG_MAX_REPL: max_repl = value[MAX_W-1:0];
				default: ;
			endcase
		endfunction

		// Moves the oldest waiting byte out as plain text.
		function void emit_oldest();
			int unsigned k;
			if (win_count == 0)
				return;
			step_bytes.push_back(window[0]);
			step_real.push_back(1'b1);
			for (k = 1; k < win_count; k++)
				window[k-1] = window[k];
			win_count--;
		endfunction

		function void note_item(logic [BYTE_W-1:0] b, logic present, logic eot);
			int unsigned         plen;
			int unsigned         rlen;
			logic [2*WORD_W-1:0] pat;
			logic [2*WORD_W-1:0] rep;
			logic                hit;
			logic                allowed;
			int                  k;
			text_out_t           r;
			plen = (pat_len > PAT_LIM) ? PAT_LIM : pat_len;
			rlen = (rep_len > REP_LIM) ? REP_LIM : rep_len;
			pat  = {pat_hi, pat_lo};
			rep  = {rep_hi, rep_lo};
			step_bytes.delete();
			step_real.delete();
			if (present && win_count < PATTERN_MAX) begin
				window[win_count] = b;
				win_count++;
			end
			if (win_count > plen) begin
				// The pattern got shorter while bytes were waiting: trim without testing.
				while (win_count > 0 && win_count + 1 > plen)
					emit_oldest();
			end else if (plen > 0 && win_count == plen) begin
				allowed = (max_repl >= UNLIMITED_MARK) || (repl_count < max_repl);
				hit = 1'b1;
				for (k = 0; k < plen; k++)
					if (window[k] != pat[BYTE_W*k +: BYTE_W])
						hit = 1'b0;
				if (hit && allowed) begin
					for (k = 0; k < rlen; k++) begin
						step_bytes.push_back(rep[BYTE_W*k +: BYTE_W]);
						step_real.push_back(1'b1);
					end
					win_count = 0;
					if (repl_count != COUNTER_TOP)
						repl_count++;
				end else begin
					emit_oldest();
				end
			end
			if (eot) begin
				while (win_count > 0)
					emit_oldest();
				if (step_bytes.size() == 0) begin
					step_bytes.push_back('0);
					step_real.push_back(1'b0);
				end
			end
			for (k = 0; k < step_bytes.size(); k++) begin
				r.data    = step_bytes[k];
				r.present = step_real[k];
				r.last    = eot && (k == step_bytes.size() - 1);
				r.made    = repl_count;
				expected_text.push_back(r);
			end
			if (eot)
				repl_count = '0;
		endfunction

		function void check_result(text_out_t got);
			text_out_t want;
			results_seen++;
			if (expected_text.size() == 0) begin
				failures++;
				if (reported < REPORT_LIMIT) begin
					reported++;
					$display("result %0d arrived with none expected: byte %02h present %0b last %0b count %0d",
						results_seen, got.data, got.present, got.last, got.made);
				end
				return;
			end
			want = expected_text.pop_front();
			if (got.data !== want.data || got.present !== want.present ||
					got.last !== want.last || got.made !== want.made) begin
				failures++;
				if (reported < REPORT_LIMIT) begin
					reported++;
					$display("result %0d mismatch: expected byte %02h present %0b last %0b count %0d",
						results_seen, want.data, want.present, want.last, want.made);
					$display("result %0d mismatch:      got byte %02h present %0b last %0b count %0d",
						results_seen, got.data, got.present, got.last, got.made);
				end
			end
		endfunction

		function int close_out();
			if (expected_text.size() != 0) begin
				$display("%0d expected result items never arrived", expected_text.size());
				failures += expected_text.size();
			end
			return failures;
		endfunction
	endclass

	logic                clk              = 1'b0;
	logic                arst_n           = 1'b0;
	logic                cfg_wr_en        = 1'b0;
	reg_idx_t            cfg_index        = REG_PAT_LO;
	logic [WORD_W-1:0]   cfg_data         = '0;
	logic                in_valid         = 1'b0;
	logic                in_stall;
	logic [BYTE_W-1:0]   text_byte        = '0;
	logic                byte_present     = 1'b0;
	logic                end_of_text      = 1'b0;
	logic                out_valid;
	logic                out_stall        = 1'b0;
	logic [BYTE_W-1:0]   out_byte;
	logic                out_byte_present;
	logic                out_last;
	logic [CTR_W-1:0]    replacements_made;

	text_scoreboard      sb;
	int                  cycle_count      = 0;
	int                  items_sent       = 0;
	int                  texts_sent       = 0;
	int                  settings_loaded  = 0;
	int                  burst_left       = 0;
	int                  random_from      = 0;
	logic                gaps_on          = 1'b1;
	logic                stall_on         = 1'b1;
	stall_mode_t         stall_mode       = STALL_NONE;
	int                  stall_countdown  = 0;
	logic [2*WORD_W-1:0] cur_pat          = '0;
	int                  cur_plen         = 0;
	logic [BYTE_W-1:0]   alphabet [ALPHABET_SIZE];

	stream_search_and_replace dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.text_byte         (text_byte),
		.byte_present      (byte_present),
		.end_of_text       (end_of_text),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_byte          (out_byte),
		.out_byte_present  (out_byte_present),
		.out_last          (out_last),
		.replacements_made (replacements_made)
	);

	always #CLK_HALF clk = ~clk;

	// The watchdog ends a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d result items outstanding",
				cycle_count, sb.expected_text.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: the outputs are sampled at the edge, before the block updates them,
	// so a result item counts as taken when valid was high and stall low going in.
	// The stall pattern switches at random between none, light, heavy and periodic.
	always @(posedge clk) begin : receiver
		text_out_t seen;
		logic      want_stall;
		if (arst_n && out_valid && !out_stall) begin
			seen.data    = out_byte;
			seen.present = out_byte_present;
			seen.last    = out_last;
			seen.made    = replacements_made;
			sb.check_result(seen);
		end
		if (stall_countdown == 0) begin
			stall_mode      <= stall_mode_t'($urandom_range(0, 3));
			stall_countdown <= $urandom_range(20, 200);
		end else begin
			stall_countdown <= stall_countdown - 1;
		end
		case (stall_mode)
			STALL_LIGHT:    want_stall = ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    want_stall = ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: want_stall = (cycle_count % 5 < 2);
			default:        want_stall = 1'b0;
		endcase
		out_stall <= stall_on && want_stall;
	end

	// Offers one item and waits for it to be taken. The sender works in bursts; at
	// the start of each burst it may drop valid for a random gap. Valid is never
	// dropped inside a burst except to drain, and the payload holds while stalled.
	task automatic send_item(input logic [BYTE_W-1:0] b, input logic p, input logic e);
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid     <= 1'b1;
		text_byte    <= b;
		byte_present <= p;
		end_of_text  <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(b, p, e);
		if (p || e)
			items_sent++;
	endtask

	// Stops sending until every expected result item has come and the block has
	// had time to finish an item that causes none.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write enable stays high across a run of writes; the caller lowers it.
	task automatic write_reg(input reg_idx_t idx, input logic [WORD_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.note_write(idx, value);
	endtask

	task automatic load_config(input logic [2*WORD_W-1:0] pat, input logic [WORD_W-1:0] plen_w,
			input logic [2*WORD_W-1:0] rep, input logic [WORD_W-1:0] rlen_w,
			input logic [WORD_W-1:0] max_w);
		wait_drained();
		write_reg(REG_PAT_LO, pat[WORD_W-1:0]);
		write_reg(REG_PAT_HI, pat[2*WORD_W-1:WORD_W]);
		write_reg(REG_PAT_LEN, plen_w);
		write_reg(REG_REPL_LO, rep[WORD_W-1:0]);
		write_reg(REG_REPL_HI, rep[2*WORD_W-1:WORD_W]);
		write_reg(REG_REPL_LEN, rlen_w);
		write_reg(REG_MAX_REPL, max_w);
		cfg_wr_en <= 1'b0;
		cur_pat  = pat;
		cur_plen = (plen_w[LEN_W-1:0] > PAT_LIM) ? PAT_LIM : int'(plen_w[LEN_W-1:0]);
		settings_loaded++;
	endtask

	// Draws a small alphabet and builds the pattern from it, so that ordinary text
	// drawn from the same alphabet hits partial and full matches often. Length and
	// limit words sometimes carry random bits above the register width.
	task automatic load_random_config();
		logic [2*WORD_W-1:0] pat;
		logic [2*WORD_W-1:0] rep;
		logic [WORD_W-1:0]   plen_w;
		logic [WORD_W-1:0]   rlen_w;
		logic [WORD_W-1:0]   max_w;
		int                  sel;
		int                  k;
		for (k = 0; k < ALPHABET_SIZE; k++)
			alphabet[k] = BYTE_W'($urandom);
		for (k = 0; k < NUM_BYTES; k++)
			pat[BYTE_W*k +: BYTE_W] = alphabet[$urandom_range(0, ALPHABET_SIZE - 1)];
		rep    = {$urandom, $urandom, $urandom, $urandom};
		plen_w = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
		rlen_w = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
		max_w  = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
		sel = $urandom_range(0, 99);
		if (sel < 5)
			plen_w[LEN_W-1:0] = '0;
		else if (sel < 65)
			plen_w[LEN_W-1:0] = LEN_W'($urandom_range(1, 4));
		else if (sel < 90)
			plen_w[LEN_W-1:0] = LEN_W'($urandom_range(5, 16));
		else
			plen_w[LEN_W-1:0] = LEN_W'($urandom_range(17, 31));
		sel = $urandom_range(0, 99);
		if (sel < 15)
			rlen_w[LEN_W-1:0] = '0;
		else if (sel < 70)
			rlen_w[LEN_W-1:0] = LEN_W'($urandom_range(1, 6));
		else if (sel < 90)
			rlen_w[LEN_W-1:0] = LEN_W'($urandom_range(7, 16));
		else
			rlen_w[LEN_W-1:0] = LEN_W'($urandom_range(17, 31));
		case ($urandom_range(0, 6))
			0:       max_w[MAX_W-1:0] = '0;
			1:       max_w[MAX_W-1:0] = MAX_W'(1);
			2:       max_w[MAX_W-1:0] = MAX_W'($urandom_range(2, 5));
			5:       max_w[MAX_W-1:0] = '1;
			6:       max_w[MAX_W-1:0] = MAX_W'($urandom);
			default: max_w[MAX_W-1:0] = UNLIMITED_MARK;
		endcase
		load_config(pat, plen_w, rep, rlen_w, max_w);
	endtask

	// One random text: mostly alphabet bytes and whole pattern copies (some with the
	// last byte spoiled), with full range noise bytes and idle items mixed in. Now and
	// then the sender pauses until all results are in, or the registers change in the
	// middle of the text while bytes are waiting in the window.
	task automatic send_random_text(input int n);
		int                k;
		int                j;
		int                sel;
		logic [BYTE_W-1:0] b;
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 3)
				load_random_config();
			else if (sel < 6)
				wait_drained();
			sel = $urandom_range(0, 99);
			if (sel < 15 && cur_plen > 0) begin
				for (j = 0; j < cur_plen; j++) begin
					b = cur_pat[BYTE_W*j +: BYTE_W];
					if (j == cur_plen - 1 && $urandom_range(0, 7) == 0)
						b = b ^ BYTE_W'($urandom_range(1, 255));
					send_item(b, 1'b1, 1'b0);
				end
			end else if (sel < 22) begin
				send_item(BYTE_W'($urandom), 1'b0, 1'b0);
			end else if (sel < 35) begin
				send_item(BYTE_W'($urandom), 1'b1, 1'b0);
			end else begin
				send_item(alphabet[$urandom_range(0, ALPHABET_SIZE - 1)], 1'b1, 1'b0);
			end
		end
		if ($urandom_range(0, 3) == 0)
			send_item(BYTE_W'($urandom), 1'b0, 1'b1);
		else
			send_item(alphabet[$urandom_range(0, ALPHABET_SIZE - 1)], 1'b1, 1'b1);
		texts_sent++;
	endtask

	initial begin : stimulus
		int k;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values: the pattern is empty, so every byte passes
		// straight through and an idle item causes nothing.
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b0);
		send_item(8'h5A, 1'b1, 1'b1);
		// A text with no bytes at all gives a single bare end marker.
		send_item(8'hC3, 1'b0, 1'b1);
		texts_sent += 2;

		// Three byte pattern: a match, a false start, then a match that ends on the last byte.
		load_config(128'h636261, 64'd3, 128'h5A5958_5756, 64'd5, WORD_W'(UNLIMITED_MARK));
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		texts_sent++;

		// Matches are deleted, and with a limit of one the second match stays as text.
		load_config({{WORD_W{1'b1}}, 64'hFFFF_FFFF_FFFF_00FF}, 64'd2, {2*WORD_W{1'b1}},
			64'd0, 64'd1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		texts_sent++;

		// Over-long lengths are clamped to sixteen. With four bytes waiting, the
		// pattern is cut to two bytes, so the next item trims the window before the
		// last one completes a match that yields a full sixteen byte replacement.
		load_config({$urandom, $urandom, $urandom, $urandom}, 64'd31,
			{$urandom, $urandom, $urandom, $urandom}, 64'd20, WORD_W'(UNLIMITED_MARK));
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		load_config(128'h2211, 64'd2, {$urandom, $urandom, $urandom, $urandom}, 64'd20,
			64'd0);
		send_item(8'h11, 1'b1, 1'b0);
		load_config(128'h2211, 64'd2, {$urandom, $urandom, $urandom, $urandom}, 64'd20,
			WORD_W'(UNLIMITED_MARK));
		send_item(8'h22, 1'b1, 1'b1);
		texts_sent++;

		// Random texts under random register settings.
		random_from = items_sent;
		load_random_config();
		while (items_sent < random_from + RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				load_random_config();
			send_random_text(($urandom_range(0, 5) == 0) ? $urandom_range(25, 50)
				: $urandom_range(0, 16));
		end

		// A text of back to back single byte matches, each replaced by one byte, shows
		// the count rising on every result. Idling is off here. A short text after it
		// shows the count cleared again.
		gaps_on = 1'b0;
		stall_on <= 1'b0;
		load_config({{(2*WORD_W-BYTE_W){1'b0}}, 8'hA5}, 64'd1, '0, 64'd1, {WORD_W{1'b1}});
		for (k = 0; k < COUNT_RUN; k++)
			send_item(8'hA5, 1'b1, 1'b0);
		send_item(8'hA5, 1'b1, 1'b1);
		send_item(8'hA5, 1'b1, 1'b1);
		texts_sent += 2;
		gaps_on = 1'b1;
		stall_on <= 1'b1;

		wait_drained();
		void'(sb.close_out());
		$display("Sent %0d text items in %0d texts under %0d register settings; %0d results checked.",
			items_sent, texts_sent, settings_loaded, sb.results_seen);
		$display("One text ran %0d back to back matches; the next showed the count cleared.",
			COUNT_RUN + 1);
		if (sb.failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
